/* src/rrpg_pkg.sv */
// rrpg_pkg: shared types, widths and segment codes for the rounded-rectangle
// path generator. No dependencies.
package rrpg_pkg;

	localparam int CW     = 24;   // coordinate width, Q16.8
	localparam int RW     = 23;   // clamped radius width (non-negative)
	localparam int EW     = 24;   // edge length / radius sum width
	localparam int NUMW   = RW + EW;
	localparam int NLANE  = 8;
	localparam int DIVST  = RW;   // one quotient bit per stage
	localparam int LANEW  = 3;
	localparam int SEGW   = 4;

	localparam logic [15:0] KAPPA_Q16 = 16'd36195;

	// lane order through the scaler: horizontal radii first, then vertical
	localparam logic [LANEW-1:0] LN_TLX = 3'd0;
	localparam logic [LANEW-1:0] LN_TRX = 3'd1;
	localparam logic [LANEW-1:0] LN_BRX = 3'd2;
	localparam logic [LANEW-1:0] LN_BLX = 3'd3;
	localparam logic [LANEW-1:0] LN_TLY = 3'd4;
	localparam logic [LANEW-1:0] LN_TRY = 3'd5;
	localparam logic [LANEW-1:0] LN_BRY = 3'd6;
	localparam logic [LANEW-1:0] LN_BLY = 3'd7;

	localparam logic [SEGW-1:0] SEG_LAST_IDX  = 4'd9;
	localparam logic [SEGW-1:0] SEQ_LAST_IDX  = 4'd9;
	localparam logic [SEGW-1:0] SEQ_ISSUE_END = 4'd8;

	typedef enum logic [1:0] {
		SEG_MOVE  = 2'd0,
		SEG_LINE  = 2'd1,
		SEG_CUBIC = 2'd2,
		SEG_CLOSE = 2'd3
	} seg_kind_t;

	typedef struct packed {
		logic [CW-1:0] l;
		logic [CW-1:0] t;
		logic [CW-1:0] r;
		logic [CW-1:0] b;
	} rect_t;

	// one radius beat travelling through the scaler
	typedef struct packed {
		logic [LANEW-1:0] lane;
		logic [RW-1:0]    rad;
		logic [EW-1:0]    m;
		logic             scale;
		rect_t            rc;
	} beat_t;

	// Bezier handle length: (r * kappa + half) >> 16
	function automatic logic [RW-1:0] kap(input logic [RW-1:0] r);
		logic [RW+16:0] p;
		p = {1'b0, r} * {{(RW-15){1'b0}}, KAPPA_Q16} + (RW+17)'(32768);
		return p[RW+15:16];
	endfunction

endpackage

/* src/rounded_rect_path_generator_top.sv */
// rounded_rect_path_generator_top: rectangle + eight radii in, ten outline
// segments out. Depends on rrpg_pkg.
//
// One rectangle is taken at a time: start with busy low is one accepted beat,
// and busy stays high after it until the sequencer, feeding the eight radii
// one per cycle into the shared scaling pipeline, reaches its last count. Ten
// result beats follow, one per cycle back to back, each marked by strobe for
// one cycle with no way to hold them off; last_segment marks the close. On
// the way to the first strobe the eight radii issue one per cycle, and the
// last of them then passes issue, multiply, 23 restoring-divide stages (one
// quotient bit each, radius * edge / largest sum), handle multiply, collect
// and the output register. Items overlap in the scaler, so a new rectangle
// may go in while the previous outline is still coming out.
module rounded_rect_path_generator_top
	import rrpg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] rect_left,
	input  logic signed [CW-1:0] rect_top,
	input  logic signed [CW-1:0] rect_right,
	input  logic signed [CW-1:0] rect_bottom,
	input  logic signed [CW-1:0] top_left_rx,
	input  logic signed [CW-1:0] top_left_ry,
	input  logic signed [CW-1:0] top_right_rx,
	input  logic signed [CW-1:0] top_right_ry,
	input  logic signed [CW-1:0] bottom_right_rx,
	input  logic signed [CW-1:0] bottom_right_ry,
	input  logic signed [CW-1:0] bottom_left_rx,
	input  logic signed [CW-1:0] bottom_left_ry,
	output logic                 strobe,
	output logic [1:0]           seg_kind,
	output logic signed [CW-1:0] ctrl1_x,
	output logic signed [CW-1:0] ctrl1_y,
	output logic signed [CW-1:0] ctrl2_x,
	output logic signed [CW-1:0] ctrl2_y,
	output logic signed [CW-1:0] end_x,
	output logic signed [CW-1:0] end_y,
	output logic                 last_segment
);

	// ---------------- capture: clamp radii, edge lengths, radius sums
	logic            accept;
	logic            seq_act_q;
	logic [SEGW-1:0] seq_cnt_q;
	rect_t           rc_q;
	logic [RW-1:0]   rad_q [NLANE];
	logic [EW-1:0]   w_q, h_q;
	logic [EW-1:0]   sum_top_q, sum_bot_q, sum_lft_q, sum_rgt_q;

	logic [RW-1:0]   rad_c [NLANE];
	logic signed [CW:0] w_raw, h_raw;

	function automatic logic [RW-1:0] clamp0(input logic signed [CW-1:0] v);
		return v[CW-1] ? '0 : v[RW-1:0];
	endfunction

	always_comb begin
		rad_c[LN_TLX] = clamp0(top_left_rx);
		rad_c[LN_TRX] = clamp0(top_right_rx);
		rad_c[LN_BRX] = clamp0(bottom_right_rx);
		rad_c[LN_BLX] = clamp0(bottom_left_rx);
		rad_c[LN_TLY] = clamp0(top_left_ry);
		rad_c[LN_TRY] = clamp0(top_right_ry);
		rad_c[LN_BRY] = clamp0(bottom_right_ry);
		rad_c[LN_BLY] = clamp0(bottom_left_ry);
		w_raw = (CW+1)'(rect_right) - (CW+1)'(rect_left);
		h_raw = (CW+1)'(rect_bottom) - (CW+1)'(rect_top);
	end

	assign busy   = seq_act_q && (seq_cnt_q != SEQ_LAST_IDX);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			rc_q      <= '{l: rect_left, t: rect_top, r: rect_right, b: rect_bottom};
			rad_q     <= rad_c;
			w_q       <= w_raw[CW] ? '0 : w_raw[EW-1:0];
			h_q       <= h_raw[CW] ? '0 : h_raw[EW-1:0];
			sum_top_q <= EW'(rad_c[LN_TLX]) + EW'(rad_c[LN_TRX]);
			sum_bot_q <= EW'(rad_c[LN_BLX]) + EW'(rad_c[LN_BRX]);
			sum_lft_q <= EW'(rad_c[LN_TLY]) + EW'(rad_c[LN_BLY]);
			sum_rgt_q <= EW'(rad_c[LN_TRY]) + EW'(rad_c[LN_BRY]);
		end
	end

	// sequencer: radii go out on counts 0..7, next rectangle taken on count 9
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_act_q <= 1'b0;
			seq_cnt_q <= '0;
		end else if (accept) begin
			seq_act_q <= 1'b1;
			seq_cnt_q <= '0;
		end else if (seq_act_q) begin
			if (seq_cnt_q == SEQ_LAST_IDX)
				seq_act_q <= 1'b0;
			else
				seq_cnt_q <= seq_cnt_q + 1'b1;
		end
	end

	// ---------------- issue (s1): pick radius, edge and largest sum
	logic             iss_vld;
	logic [LANEW-1:0] iss_lane;
	logic [EW-1:0]    iss_e, iss_m;
	logic             vld_s1;
	beat_t            b_s1;

	assign iss_vld  = seq_act_q && (seq_cnt_q < SEQ_ISSUE_END);
	assign iss_lane = seq_cnt_q[LANEW-1:0];

	always_comb begin
		if (iss_lane[LANEW-1]) begin
			iss_e = h_q;
			iss_m = (sum_lft_q > sum_rgt_q) ? sum_lft_q : sum_rgt_q;
		end else begin
			iss_e = w_q;
			iss_m = (sum_top_q > sum_bot_q) ? sum_top_q : sum_bot_q;
		end
	end

	logic [EW-1:0] e_s1;

	always_ff @(posedge clk) begin
		b_s1.lane  <= iss_lane;
		b_s1.rad   <= rad_q[iss_lane];
		b_s1.m     <= iss_m;
		b_s1.scale <= iss_m > iss_e;
		b_s1.rc    <= rc_q;
		e_s1       <= iss_e;
	end

	// ---------------- s2: radius * edge
	logic            vld_s2;
	beat_t           b_s2;
	logic [NUMW-1:0] num_s2;

	always_ff @(posedge clk) begin
		b_s2   <= b_s1;
		num_s2 <= NUMW'(b_s1.rad) * NUMW'(e_s1);
	end

	// ---------------- divide stages: one quotient bit each
	// remainder starts below the divisor since the quotient fits RW bits
	logic          dv_vld_s [DIVST];
	beat_t         dv_b_s   [DIVST];
	logic [EW-1:0] dv_rem_s [DIVST];
	logic [RW-1:0] dv_lo_s  [DIVST];
	logic [RW-1:0] dv_q_s   [DIVST];

	for (genvar k = 0; k < DIVST; k++) begin : g_div
		beat_t         b_in;
		logic [EW-1:0] rem_in;
		logic [RW-1:0] lo_in, q_in;
		logic [EW:0]   trial;
		logic          fits;

		if (k == 0) begin : g_first
			assign b_in   = b_s2;
			assign rem_in = num_s2[NUMW-1:RW];
			assign lo_in  = num_s2[RW-1:0];
			assign q_in   = '0;
		end else begin : g_next
			assign b_in   = dv_b_s[k-1];
			assign rem_in = dv_rem_s[k-1];
			assign lo_in  = dv_lo_s[k-1];
			assign q_in   = dv_q_s[k-1];
		end

		assign trial = {rem_in, lo_in[RW-1]};
		assign fits  = trial >= {1'b0, b_in.m};

		always_ff @(posedge clk) begin
			dv_b_s[k]   <= b_in;
			dv_rem_s[k] <= fits ? EW'(trial - {1'b0, b_in.m}) : trial[EW-1:0];
			dv_lo_s[k]  <= {lo_in[RW-2:0], 1'b0};
			dv_q_s[k]   <= {q_in[RW-2:0], fits};
		end
	end

	// ---------------- handle stage: final radius and its Bezier offset
	logic             vld_hk;
	logic [LANEW-1:0] lane_hk;
	logic [RW-1:0]    rad_hk, kap_hk;
	rect_t            rc_hk;
	logic [RW-1:0]    fin_c;

	assign fin_c = dv_b_s[DIVST-1].scale ? dv_q_s[DIVST-1] : dv_b_s[DIVST-1].rad;

	always_ff @(posedge clk) begin
		lane_hk <= dv_b_s[DIVST-1].lane;
		rad_hk  <= fin_c;
		kap_hk  <= kap(fin_c);
		rc_hk   <= dv_b_s[DIVST-1].rc;
	end

	// valid bits of the whole scaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_hk <= 1'b0;
			for (int i = 0; i < DIVST; i++)
				dv_vld_s[i] <= 1'b0;
		end else begin
			vld_s1      <= iss_vld;
			vld_s2      <= vld_s1;
			dv_vld_s[0] <= vld_s2;
			for (int i = 1; i < DIVST; i++)
				dv_vld_s[i] <= dv_vld_s[i-1];
			vld_hk      <= dv_vld_s[DIVST-1];
		end
	end

	// ---------------- collect eight radii, hand a full set to the emitter
	logic [RW-1:0] col_r_q [NLANE];
	logic [RW-1:0] col_k_q [NLANE];
	logic [RW-1:0] em_r_q  [NLANE];
	logic [RW-1:0] em_k_q  [NLANE];
	rect_t         em_rc_q;
	logic          em_load;
	logic          em_act_q;
	logic [SEGW-1:0] em_cnt_q;

	assign em_load = vld_hk && (lane_hk == LN_BLY);

	always_ff @(posedge clk) begin
		if (vld_hk) begin
			col_r_q[lane_hk] <= rad_hk;
			col_k_q[lane_hk] <= kap_hk;
		end
		if (em_load) begin
			for (int i = 0; i < NLANE; i++) begin
				em_r_q[i] <= (LANEW'(i) == LN_BLY) ? rad_hk : col_r_q[i];
				em_k_q[i] <= (LANEW'(i) == LN_BLY) ? kap_hk : col_k_q[i];
			end
			em_rc_q <= rc_hk;
		end
	end

	// a new set lands exactly as the previous tenth segment goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_act_q <= 1'b0;
			em_cnt_q <= '0;
		end else if (em_load) begin
			em_act_q <= 1'b1;
			em_cnt_q <= '0;
		end else if (em_act_q) begin
			if (em_cnt_q == SEG_LAST_IDX)
				em_act_q <= 1'b0;
			else
				em_cnt_q <= em_cnt_q + 1'b1;
		end
	end

	// ---------------- segment build, 24-bit wrap arithmetic
	logic [CW-1:0] L, T, R, B;
	logic [CW-1:0] tlx, tly, trx, try_r, brx, bry, blx, bly;
	logic [CW-1:0] ktlx, ktly, ktrx, ktry, kbrx, kbry, kblx, kbly;
	seg_kind_t     sk_c;
	logic [CW-1:0] c1x_c, c1y_c, c2x_c, c2y_c, ex_c, ey_c;

	assign L = em_rc_q.l;
	assign T = em_rc_q.t;
	assign R = em_rc_q.r;
	assign B = em_rc_q.b;
	assign tlx   = CW'(em_r_q[LN_TLX]);
	assign trx   = CW'(em_r_q[LN_TRX]);
	assign brx   = CW'(em_r_q[LN_BRX]);
	assign blx   = CW'(em_r_q[LN_BLX]);
	assign tly   = CW'(em_r_q[LN_TLY]);
	assign try_r = CW'(em_r_q[LN_TRY]);
	assign bry   = CW'(em_r_q[LN_BRY]);
	assign bly   = CW'(em_r_q[LN_BLY]);
	assign ktlx  = CW'(em_k_q[LN_TLX]);
	assign ktrx  = CW'(em_k_q[LN_TRX]);
	assign kbrx  = CW'(em_k_q[LN_BRX]);
	assign kblx  = CW'(em_k_q[LN_BLX]);
	assign ktly  = CW'(em_k_q[LN_TLY]);
	assign ktry  = CW'(em_k_q[LN_TRY]);
	assign kbry  = CW'(em_k_q[LN_BRY]);
	assign kbly  = CW'(em_k_q[LN_BLY]);

	always_comb begin
		sk_c  = SEG_LINE;
		c1x_c = '0;
		c1y_c = '0;
		c2x_c = '0;
		c2y_c = '0;
		ex_c  = '0;
		ey_c  = '0;
		case (em_cnt_q)
			4'd0: begin
				sk_c = SEG_MOVE;
				ex_c = L + tlx;
				ey_c = T;
			end
			4'd1: begin
				ex_c = R - trx;
				ey_c = T;
			end
			4'd2: begin
				ex_c = R;
				ey_c = T + try_r;
				if (trx != '0 && try_r != '0) begin
					sk_c  = SEG_CUBIC;
					c1x_c = R - trx + ktrx;
					c1y_c = T;
					c2x_c = R;
					c2y_c = T + try_r - ktry;
				end
			end
			4'd3: begin
				ex_c = R;
				ey_c = B - bry;
			end
			4'd4: begin
				ex_c = R - brx;
				ey_c = B;
				if (brx != '0 && bry != '0) begin
					sk_c  = SEG_CUBIC;
					c1x_c = R;
					c1y_c = B - bry + kbry;
					c2x_c = R - brx + kbrx;
					c2y_c = B;
				end
			end
			4'd5: begin
				ex_c = L + blx;
				ey_c = B;
			end
			4'd6: begin
				ex_c = L;
				ey_c = B - bly;
				if (blx != '0 && bly != '0) begin
					sk_c  = SEG_CUBIC;
					c1x_c = L + blx - kblx;
					c1y_c = B;
					c2x_c = L;
					c2y_c = B - bly + kbly;
				end
			end
			4'd7: begin
				ex_c = L;
				ey_c = T + tly;
			end
			4'd8: begin
				ex_c = L + tlx;
				ey_c = T;
				if (tlx != '0 && tly != '0) begin
					sk_c  = SEG_CUBIC;
					c1x_c = L;
					c1y_c = T + tly - ktly;
					c2x_c = L + tlx - ktlx;
					c2y_c = T;
				end
			end
			4'd9: begin
				sk_c = SEG_CLOSE;
			end
			default: begin
				sk_c = SEG_CLOSE;
			end
		endcase
	end

	// ---------------- output register
	always_ff @(posedge clk) begin
		seg_kind     <= sk_c;
		ctrl1_x      <= c1x_c;
		ctrl1_y      <= c1y_c;
		ctrl2_x      <= c2x_c;
		ctrl2_y      <= c2y_c;
		end_x        <= ex_c;
		end_y        <= ey_c;
		last_segment <= (em_cnt_q == SEG_LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= em_act_q;
	end

endmodule

/* src/rrpg_checker.sv */
// rrpg_checker: port-level assertions for the path generator top level,
// bound to it below. Depends on rrpg_pkg.
module rrpg_checker
	import rrpg_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [1:0] seg_kind,
	input logic       last_segment
);

	// a taken beat blocks the next one for the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted beat");

	// closing beat carries the close code
	a_last_close: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_segment) |-> (seg_kind == SEG_CLOSE))
		else $error("last segment is not a close");

	// a move opens a run that continues next cycle
	a_move_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && seg_kind == SEG_MOVE) |=> (strobe && !last_segment))
		else $error("outline run broken after move");

	// closes never come back to back
	a_close_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_segment) |=> !(strobe && last_segment))
		else $error("two closing beats in a row");

endmodule

bind rounded_rect_path_generator_top rrpg_checker u_rrpg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.seg_kind     (seg_kind),
	.last_segment (last_segment)
);
